[design/phc_pkg.sv]
// ----------------------------------------------------------------------------
// phc_pkg
// Shared widths, reset values, register indexes and interface types of the
// pixel hit clusterer.
// ----------------------------------------------------------------------------
package phc_pkg;

   localparam int COL_W     = 9;
   localparam int ROW_W     = 8;
   localparam int ADC_W     = 8;
   localparam int CHG_W     = 11;
   localparam int QEFF_W    = 10;
   localparam int SIZE_W    = 7;
   localparam int ADC_SUM_W = 14;
   localparam int Q_SUM_W   = 16;
   localparam int CC_W      = 13;
   localparam int CR_W      = 12;
   localparam int WC_W      = 25;
   localparam int WR_W      = 24;
   localparam int RAD_W     = 2;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   localparam logic [QEFF_W-1:0] NEG_CHARGE        = 10'd4;
   localparam logic [RAD_W-1:0]  RADIUS_RST        = 2'd1;
   localparam logic [COL_W-1:0]  EDGE_COL_LOW_RST  = 9'd0;
   localparam logic [COL_W-1:0]  EDGE_COL_HIGH_RST = 9'd51;
   localparam logic [ROW_W-1:0]  EDGE_ROW_RST      = 8'd79;

   typedef enum logic [1:0] {
      REG_RADIUS        = 2'd0,
      REG_EDGE_COL_LOW  = 2'd1,
      REG_EDGE_COL_HIGH = 2'd2,
      REG_EDGE_ROW      = 2'd3
   } phc_reg_type;

   typedef struct packed {
      logic [RAD_W-1:0] radius;
      logic [COL_W-1:0] edge_col_low;
      logic [COL_W-1:0] edge_col_high;
      logic [ROW_W-1:0] edge_row;
   } phc_cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [ADC_W-1:0] adc;
      logic [CHG_W-1:0] charge;
   } phc_hit_type;

   typedef struct packed {
      logic load;
      logic frame_start;
      logic frame_done;
      logic seed_next;
      logic seed_begin;
      logic seed_load;
      logic pop;
      logic memb_rd;
      logic memb_load;
      logic scan_rd;
      logic scan_cmp;
      logic div_start;
      logic div_row;
      logic col_latch;
      logic emit;
   } phc_cmd_type;

   typedef struct packed {
      logic seed_end;
      logic seed_used;
      logic queue_empty;
      logic scan_end;
      logic acc_idle;
      logic div_done;
   } phc_sts_type;

endpackage

[design/pixel_hit_clusterer.sv]
// A hit request is taken without raising busy; a request that ends the frame holds
// busy while clusters are grown and emitted, each result on the one-cycle rsp_valid
// strobe, which the receiver cannot stall. Each cluster adds two serial divisions
// to its growth. Synchronous active-high reset empties the hit store and restores
// registers.
// ----------------------------------------------------------------------------
// pixel_hit_clusterer
// Groups one frame of pixel hits into clusters by flood growth and reports
// size, sums, charge-weighted centroid and edge flags per cluster.
// ----------------------------------------------------------------------------
module pixel_hit_clusterer #(
   parameter int MAX_HITS           = 64,
   parameter int CENTROID_FRAC_BITS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_hit_valid,
   input  logic [phc_pkg::COL_W-1:0]            req_hit_col,
   input  logic [phc_pkg::ROW_W-1:0]            req_hit_row,
   input  logic [phc_pkg::ADC_W-1:0]            req_hit_adc,
   input  logic signed [phc_pkg::CHG_W-1:0]     req_hit_charge,
   input  logic                                 req_end_of_frame,
   output logic                                 rsp_valid,
   output logic [phc_pkg::SIZE_W-1:0]           rsp_cluster_size,
   output logic [phc_pkg::ADC_SUM_W-1:0]        rsp_adc_sum,
   output logic [phc_pkg::Q_SUM_W-1:0]          rsp_charge_sum,
   output logic [phc_pkg::CC_W-1:0]             rsp_centroid_col,
   output logic [phc_pkg::CR_W-1:0]             rsp_centroid_row,
   output logic                                 rsp_touches_big_x,
   output logic                                 rsp_touches_big_y,
   output logic                                 rsp_last_cluster,
   output logic                                 rsp_hits_dropped,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [phc_pkg::CSR_AW-1:0]           paddr,
   input  logic [phc_pkg::CSR_DW-1:0]           pwdata,
   output logic [phc_pkg::CSR_DW-1:0]           prdata,
   output logic                                 pready
);
   import phc_pkg::*;

   phc_cfg_type cfg_ff;
   phc_cmd_type cmd;
   phc_sts_type sts;
   phc_reg_type reg_sel;
   logic        csr_wr;

   assign reg_sel = phc_reg_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius        <= RADIUS_RST;
         cfg_ff.edge_col_low  <= EDGE_COL_LOW_RST;
         cfg_ff.edge_col_high <= EDGE_COL_HIGH_RST;
         cfg_ff.edge_row      <= EDGE_ROW_RST;
      end else if (csr_wr) begin
         case (reg_sel)
            REG_RADIUS:        cfg_ff.radius        <= pwdata[RAD_W-1:0];
            REG_EDGE_COL_LOW:  cfg_ff.edge_col_low  <= pwdata[COL_W-1:0];
            REG_EDGE_COL_HIGH: cfg_ff.edge_col_high <= pwdata[COL_W-1:0];
            REG_EDGE_ROW:      cfg_ff.edge_row      <= pwdata[ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_RADIUS:        prdata = CSR_DW'(cfg_ff.radius);
         REG_EDGE_COL_LOW:  prdata = CSR_DW'(cfg_ff.edge_col_low);
         REG_EDGE_COL_HIGH: prdata = CSR_DW'(cfg_ff.edge_col_high);
         REG_EDGE_ROW:      prdata = CSR_DW'(cfg_ff.edge_row);
         default:           prdata = '0;
      endcase
   end

   phc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_end_of_frame (req_end_of_frame),
      .busy             (busy),
      .cmd              (cmd),
      .sts              (sts)
   );

   phc_datapath #(
      .MAX_HITS  (MAX_HITS),
      .FRAC_BITS (CENTROID_FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd               (cmd),
      .sts               (sts),
      .req_hit_valid     (req_hit_valid),
      .req_hit_col       (req_hit_col),
      .req_hit_row       (req_hit_row),
      .req_hit_adc       (req_hit_adc),
      .req_hit_charge    ($unsigned(req_hit_charge)),
      .rsp_valid         (rsp_valid),
      .rsp_cluster_size  (rsp_cluster_size),
      .rsp_adc_sum       (rsp_adc_sum),
      .rsp_charge_sum    (rsp_charge_sum),
      .rsp_centroid_col  (rsp_centroid_col),
      .rsp_centroid_row  (rsp_centroid_row),
      .rsp_touches_big_x (rsp_touches_big_x),
      .rsp_touches_big_y (rsp_touches_big_y),
      .rsp_last_cluster  (rsp_last_cluster),
      .rsp_hits_dropped  (rsp_hits_dropped)
   );

`ifndef SYNTHESIS
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a clustering pass");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes on consecutive cycles");

   a_hit_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_end_of_frame) |=> !busy)
      else $error("busy raised by a request that does not end the frame");

   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cluster_size != '0))
      else $error("empty cluster reported");
`endif

endmodule

[design/phc_divider.sv]
// ----------------------------------------------------------------------------
// phc_divider
// Restoring divider that produces one quotient bit per cycle and keeps the
// low quotient bits.
// ----------------------------------------------------------------------------
module phc_divider #(
   parameter int NUM_W = 29,
   parameter int DEN_W = 16,
   parameter int QUO_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [DEN_W:0]   rem_sh;
   logic             ge;
   logic [DEN_W:0]   rem_in;

   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            num_ff <= num_ff << 1;
            rem_ff <= rem_in[DEN_W-1:0];
            quo_ff <= {quo_ff[QUO_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

[design/phc_datapath.sv]
// ----------------------------------------------------------------------------
// phc_datapath
// Hit store, flood-growth work queue, member accumulators, centroid divider
// and the result register of the pixel hit clusterer.
// ----------------------------------------------------------------------------
module phc_datapath #(
   parameter int MAX_HITS  = 64,
   parameter int FRAC_BITS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  phc_pkg::phc_cfg_type          cfg,
   input  phc_pkg::phc_cmd_type          cmd,
   output phc_pkg::phc_sts_type          sts,
   input  logic                          req_hit_valid,
   input  logic [phc_pkg::COL_W-1:0]     req_hit_col,
   input  logic [phc_pkg::ROW_W-1:0]     req_hit_row,
   input  logic [phc_pkg::ADC_W-1:0]     req_hit_adc,
   input  logic [phc_pkg::CHG_W-1:0]     req_hit_charge,
   output logic                          rsp_valid,
   output logic [phc_pkg::SIZE_W-1:0]    rsp_cluster_size,
   output logic [phc_pkg::ADC_SUM_W-1:0] rsp_adc_sum,
   output logic [phc_pkg::Q_SUM_W-1:0]   rsp_charge_sum,
   output logic [phc_pkg::CC_W-1:0]      rsp_centroid_col,
   output logic [phc_pkg::CR_W-1:0]      rsp_centroid_row,
   output logic                          rsp_touches_big_x,
   output logic                          rsp_touches_big_y,
   output logic                          rsp_last_cluster,
   output logic                          rsp_hits_dropped
);
   import phc_pkg::*;

   localparam int IDX_W = $clog2(MAX_HITS);
   localparam int CNT_W = $clog2(MAX_HITS + 1);
   localparam int NUM_W = WC_W + FRAC_BITS;
   localparam int PC_W  = COL_W + QEFF_W;
   localparam int PR_W  = ROW_W + QEFF_W;

   phc_hit_type      store_mem [MAX_HITS];
   logic [IDX_W-1:0] queue_mem [MAX_HITS];

   phc_hit_type      rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] q_rd_ff;
   logic [CNT_W-1:0] n_ff;
   logic             ovf_ff;
   logic [MAX_HITS-1:0] used_ff;
   logic [CNT_W-1:0] used_cnt_ff;
   logic [CNT_W-1:0] seed_ff;
   logic [CNT_W-1:0] scan_ff;
   logic [CNT_W-1:0] head_ff;
   logic [CNT_W-1:0] tail_ff;
   logic [COL_W-1:0] memb_col_ff;
   logic [ROW_W-1:0] memb_row_ff;
   logic [COL_W-1:0] seed_col_ff;
   logic [ROW_W-1:0] seed_row_ff;

   logic             a_vld_ff;
   logic [COL_W-1:0] a_col_ff;
   logic [ROW_W-1:0] a_row_ff;
   logic [ADC_W-1:0] a_adc_ff;
   logic [QEFF_W-1:0] a_q_ff;
   logic             a_bx_ff;
   logic             a_by_ff;
   logic             b_vld_ff;
   logic [PC_W-1:0]  b_pc_ff;
   logic [PR_W-1:0]  b_pr_ff;
   logic [ADC_W-1:0] b_adc_ff;
   logic [QEFF_W-1:0] b_q_ff;
   logic             b_bx_ff;
   logic             b_by_ff;

   logic [SIZE_W-1:0]    size_ff;
   logic [ADC_SUM_W-1:0] adc_sum_ff;
   logic [Q_SUM_W-1:0]   q_sum_ff;
   logic [WC_W-1:0]      wc_ff;
   logic [WR_W-1:0]      wr_ff;
   logic                 bx_ff;
   logic                 by_ff;
   logic [CC_W-1:0]      cc_ff;

   logic                 rsp_valid_ff;
   logic [SIZE_W-1:0]    rsp_size_ff;
   logic [ADC_SUM_W-1:0] rsp_adc_ff;
   logic [Q_SUM_W-1:0]   rsp_q_ff;
   logic [CC_W-1:0]      rsp_cc_ff;
   logic [CR_W-1:0]      rsp_cr_ff;
   logic                 rsp_bx_ff;
   logic                 rsp_by_ff;
   logic                 rsp_last_ff;
   logic                 rsp_drop_ff;

   logic [COL_W-1:0] dcol;
   logic [ROW_W-1:0] drow;
   logic             near;
   logic             join_hit;
   logic             push;
   logic             full;
   phc_hit_type      wr_hit;
   logic [NUM_W-1:0] div_num;
   logic [NUM_W-1:0] seed_col_sh;
   logic [NUM_W-1:0] seed_row_sh;
   logic             div_done;
   logic [CC_W-1:0]  div_quo;
   logic             q_zero;

   always_comb begin
      if (cmd.seed_begin) begin
         rd_addr = seed_ff[IDX_W-1:0];
      end else if (cmd.memb_rd) begin
         rd_addr = q_rd_ff;
      end else begin
         rd_addr = scan_ff[IDX_W-1:0];
      end
      dcol = (rd_ff.col > memb_col_ff) ? rd_ff.col - memb_col_ff : memb_col_ff - rd_ff.col;
      drow = (rd_ff.row > memb_row_ff) ? rd_ff.row - memb_row_ff : memb_row_ff - rd_ff.row;
      near = (dcol <= COL_W'(cfg.radius)) && (drow <= ROW_W'(cfg.radius));
      join_hit = cmd.scan_cmp && !used_ff[scan_ff[IDX_W-1:0]] && near;
      push     = cmd.seed_load || join_hit;
      full     = n_ff == CNT_W'(MAX_HITS);
      wr_hit   = '{col: req_hit_col, row: req_hit_row, adc: req_hit_adc,
                   charge: req_hit_charge};
      div_num  = cmd.div_row ? (NUM_W'(wr_ff) << FRAC_BITS) : (NUM_W'(wc_ff) << FRAC_BITS);
      seed_col_sh = NUM_W'(seed_col_ff) << FRAC_BITS;
      seed_row_sh = NUM_W'(seed_row_ff) << FRAC_BITS;
      q_zero   = q_sum_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load && req_hit_valid && !full) begin
         store_mem[n_ff[IDX_W-1:0]] <= wr_hit;
      end
      if (cmd.seed_begin || cmd.memb_rd || cmd.scan_rd) begin
         rd_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.seed_begin) begin
         queue_mem[0] <= seed_ff[IDX_W-1:0];
      end else if (join_hit) begin
         queue_mem[tail_ff[IDX_W-1:0]] <= scan_ff[IDX_W-1:0];
      end
      if (cmd.pop) begin
         q_rd_ff <= queue_mem[head_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff        <= '0;
         ovf_ff      <= 1'b0;
         used_ff     <= '0;
         used_cnt_ff <= '0;
         seed_ff     <= '0;
         scan_ff     <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
      end else begin
         if (cmd.frame_done) begin
            n_ff   <= '0;
            ovf_ff <= 1'b0;
         end else if (cmd.load && req_hit_valid) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               n_ff <= n_ff + 1'b1;
            end
         end
         if (cmd.frame_start) begin
            used_ff     <= '0;
            used_cnt_ff <= '0;
            seed_ff     <= '0;
         end else if (cmd.seed_begin) begin
            used_ff[seed_ff[IDX_W-1:0]] <= 1'b1;
            used_cnt_ff <= used_cnt_ff + 1'b1;
            head_ff     <= '0;
            tail_ff     <= CNT_W'(1);
         end else if (join_hit) begin
            used_ff[scan_ff[IDX_W-1:0]] <= 1'b1;
            used_cnt_ff <= used_cnt_ff + 1'b1;
            tail_ff     <= tail_ff + 1'b1;
         end
         if (cmd.seed_next) begin
            seed_ff <= seed_ff + 1'b1;
         end
         if (cmd.pop) begin
            head_ff <= head_ff + 1'b1;
         end
         if (cmd.memb_rd) begin
            scan_ff <= '0;
         end else if (cmd.scan_cmp) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.memb_load) begin
         memb_col_ff <= rd_ff.col;
         memb_row_ff <= rd_ff.row;
      end
      if (cmd.seed_load) begin
         seed_col_ff <= rd_ff.col;
         seed_row_ff <= rd_ff.row;
      end
      a_col_ff <= rd_ff.col;
      a_row_ff <= rd_ff.row;
      a_adc_ff <= rd_ff.adc;
      a_q_ff   <= rd_ff.charge[CHG_W-1] ? NEG_CHARGE : rd_ff.charge[QEFF_W-1:0];
      a_bx_ff  <= (rd_ff.col == cfg.edge_col_low) || (rd_ff.col == cfg.edge_col_high);
      a_by_ff  <= rd_ff.row == cfg.edge_row;
      b_pc_ff  <= PC_W'(a_col_ff) * PC_W'(a_q_ff);
      b_pr_ff  <= PR_W'(a_row_ff) * PR_W'(a_q_ff);
      b_adc_ff <= a_adc_ff;
      b_q_ff   <= a_q_ff;
      b_bx_ff  <= a_bx_ff;
      b_by_ff  <= a_by_ff;
      if (cmd.seed_begin) begin
         size_ff    <= '0;
         adc_sum_ff <= '0;
         q_sum_ff   <= '0;
         wc_ff      <= '0;
         wr_ff      <= '0;
         bx_ff      <= 1'b0;
         by_ff      <= 1'b0;
      end else if (b_vld_ff) begin
         size_ff    <= size_ff + 1'b1;
         adc_sum_ff <= adc_sum_ff + ADC_SUM_W'(b_adc_ff);
         q_sum_ff   <= q_sum_ff + Q_SUM_W'(b_q_ff);
         wc_ff      <= wc_ff + WC_W'(b_pc_ff);
         wr_ff      <= wr_ff + WR_W'(b_pr_ff);
         bx_ff      <= bx_ff | b_bx_ff;
         by_ff      <= by_ff | b_by_ff;
      end
      if (cmd.col_latch) begin
         cc_ff <= div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_vld_ff     <= push;
         b_vld_ff     <= a_vld_ff;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_size_ff <= size_ff;
         rsp_adc_ff  <= adc_sum_ff;
         rsp_q_ff    <= q_sum_ff;
         rsp_cc_ff   <= q_zero ? seed_col_sh[CC_W-1:0] : cc_ff;
         rsp_cr_ff   <= q_zero ? seed_row_sh[CR_W-1:0] : div_quo[CR_W-1:0];
         rsp_bx_ff   <= bx_ff;
         rsp_by_ff   <= by_ff;
         rsp_last_ff <= used_cnt_ff == n_ff;
         rsp_drop_ff <= ovf_ff;
      end
   end

   phc_divider #(
      .NUM_W (NUM_W),
      .DEN_W (Q_SUM_W),
      .QUO_W (CC_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (q_sum_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      sts.seed_end    = seed_ff == n_ff;
      sts.seed_used   = used_ff[seed_ff[IDX_W-1:0]];
      sts.queue_empty = head_ff == tail_ff;
      sts.scan_end    = scan_ff == n_ff;
      sts.acc_idle    = !a_vld_ff && !b_vld_ff;
      sts.div_done    = div_done;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cluster_size  = rsp_size_ff;
   assign rsp_adc_sum       = rsp_adc_ff;
   assign rsp_charge_sum    = rsp_q_ff;
   assign rsp_centroid_col  = rsp_cc_ff;
   assign rsp_centroid_row  = rsp_cr_ff;
   assign rsp_touches_big_x = rsp_bx_ff;
   assign rsp_touches_big_y = rsp_by_ff;
   assign rsp_last_cluster  = rsp_last_ff;
   assign rsp_hits_dropped  = rsp_drop_ff;

endmodule

[design/phc_ctrl.sv]
// ----------------------------------------------------------------------------
// phc_ctrl
// Sequencer of the pixel hit clusterer: hit loading, seed search, flood
// growth over the work queue, centroid division and result emission.
// ----------------------------------------------------------------------------
module phc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_end_of_frame,
   output logic                 busy,
   output phc_pkg::phc_cmd_type cmd,
   input  phc_pkg::phc_sts_type sts
);
   import phc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_CHK,
      ST_SEED_LD,
      ST_POP,
      ST_MEMB_RD,
      ST_MEMB_LD,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_WAIT_ACC,
      ST_DIV_COL,
      ST_DIV_ROW
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_end_of_frame) begin
                  cmd.frame_start = 1'b1;
                  state_in        = ST_SEED_CHK;
               end
            end
         end
         ST_SEED_CHK: begin
            if (sts.seed_end) begin
               cmd.frame_done = 1'b1;
               state_in       = ST_IDLE;
            end else if (sts.seed_used) begin
               cmd.seed_next = 1'b1;
            end else begin
               cmd.seed_begin = 1'b1;
               state_in       = ST_SEED_LD;
            end
         end
         ST_SEED_LD: begin
            cmd.seed_load = 1'b1;
            state_in      = ST_POP;
         end
         ST_POP: begin
            if (sts.queue_empty) begin
               state_in = ST_WAIT_ACC;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_MEMB_RD;
            end
         end
         ST_MEMB_RD: begin
            cmd.memb_rd = 1'b1;
            state_in    = ST_MEMB_LD;
         end
         ST_MEMB_LD: begin
            cmd.memb_load = 1'b1;
            state_in      = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (sts.scan_end) begin
               state_in = ST_POP;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = ST_SCAN_RD;
         end
         ST_WAIT_ACC: begin
            if (sts.acc_idle) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_COL;
            end
         end
         ST_DIV_COL: begin
            if (sts.div_done) begin
               cmd.col_latch = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_row   = 1'b1;
               state_in      = ST_DIV_ROW;
            end
         end
         ST_DIV_ROW: begin
            if (sts.div_done) begin
               cmd.emit = 1'b1;
               state_in = ST_SEED_CHK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= state_in != ST_IDLE;
      end
   end

   assign busy = busy_ff;

endmodule
